[sv/ssl_pkg.sv]
// Shared types, constants and helpers for the six-axis servo slew limiter.
`timescale 1ns / 1ps

package ssl_pkg;

   localparam int AXES = 6;

   // Request kinds carried on req_cmd
   localparam logic CMD_MOVE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Step interval range, in ticks
   localparam logic [7:0] IVAL_MIN = 8'd10;
   localparam logic [7:0] IVAL_MAX = 8'd30;

   typedef logic [7:0] deg_type;
   typedef logic [4:0] ival_type;

   // Per-axis status from one axis stepper
   typedef struct packed {
      logic moved;
      logic arrived;
   } axis_stat_type;

   // Axis order: base, shoulder, elbow, wrist rotation, wrist vertical, gripper
   localparam deg_type LO_LIM [AXES] = '{8'd0, 8'd15, 8'd0, 8'd0, 8'd0, 8'd10};
   localparam deg_type HI_LIM [AXES] = '{8'd180, 8'd165, 8'd180, 8'd180, 8'd180, 8'd73};
   localparam deg_type HOME_POS [AXES] = '{8'd90, 8'd45, 8'd180, 8'd90, 8'd180, 8'd10};

   // Clamp a signed 10-bit target into [lo, hi]
   function automatic deg_type clamp_deg(input logic signed [9:0] v,
                                         input deg_type lo, input deg_type hi);
      logic signed [9:0] lo_s;
      logic signed [9:0] hi_s;
      lo_s = signed'({2'b00, lo});
      hi_s = signed'({2'b00, hi});
      if (v < lo_s) begin
         return lo;
      end else if (v > hi_s) begin
         return hi;
      end else begin
         return v[7:0];
      end
   endfunction

   // Clamp the requested step interval into the legal tick range
   function automatic ival_type clamp_ival(input logic [7:0] v);
      logic [7:0] c;
      c = v;
      if (c > IVAL_MAX) c = IVAL_MAX;
      if (c < IVAL_MIN) c = IVAL_MIN;
      return c[4:0];
   endfunction

endpackage

[sv/ssl_axis.sv]
// One-degree stepper for a single servo axis.
`timescale 1ns / 1ps

module ssl_axis (
   input  ssl_pkg::deg_type       pos,
   input  ssl_pkg::deg_type       tgt,
   output ssl_pkg::deg_type       pos_next,
   output ssl_pkg::axis_stat_type stat
);

   // Move one degree toward the target, hold when there
   always_comb begin
      if (pos < tgt) begin
         pos_next = pos + 8'd1;
      end else if (pos > tgt) begin
         pos_next = pos - 8'd1;
      end else begin
         pos_next = pos;
      end
      stat.moved   = (pos != tgt);
      stat.arrived = (pos_next == tgt);
   end

endmodule

[sv/six_axis_servo_slew_limiter.sv]
// Top level of the six-axis servo slew limiter.
`timescale 1ns / 1ps

// Six-axis servo slew limiter. A move request (req_cmd = 0) clamps the six
// joint targets to their axis limits and the step interval to 10..30 ticks,
// and starts a move; it produces no response. A tick request (req_cmd = 1)
// counts down the interval, and on every interval-th tick each axis not yet
// at its target steps one degree toward it, producing one response with the
// six post-step positions, the moved mask and done_res. Ticks that do not
// step, and ticks while idle, produce no response. While req_ready is high,
// one request is taken per clock: the state update and response are computed
// in one pass and the response lands in the output register at the same edge,
// so it is visible the cycle after its tick. req_ready drops only while an
// earlier response is held in the output register and rsp_ready is low.

module six_axis_servo_slew_limiter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_step_interval,
   input  logic signed [9:0] req_target_base,
   input  logic signed [9:0] req_target_shoulder,
   input  logic signed [9:0] req_target_elbow,
   input  logic signed [9:0] req_target_wrist_rotation,
   input  logic signed [9:0] req_target_wrist_vertical,
   input  logic signed [9:0] req_target_gripper,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_pos_base,
   output logic [7:0] rsp_pos_shoulder,
   output logic [7:0] rsp_pos_elbow,
   output logic [7:0] rsp_pos_wrist_rotation,
   output logic [7:0] rsp_pos_wrist_vertical,
   output logic [7:0] rsp_pos_gripper,
   output logic [5:0] rsp_moved_mask,
   output logic       rsp_done_res
);

   ssl_pkg::deg_type  pos_ff [ssl_pkg::AXES];
   ssl_pkg::deg_type  pos_in [ssl_pkg::AXES];
   ssl_pkg::deg_type  tgt_ff [ssl_pkg::AXES];
   ssl_pkg::deg_type  tgt_in [ssl_pkg::AXES];
   ssl_pkg::deg_type  pos_step [ssl_pkg::AXES];
   ssl_pkg::deg_type  tgt_req [ssl_pkg::AXES];
   ssl_pkg::axis_stat_type stat [ssl_pkg::AXES];
   logic signed [9:0] req_tgt [ssl_pkg::AXES];

   ssl_pkg::ival_type interval_ff, interval_in, ival_req;
   logic [4:0]        countdown_ff, countdown_in;
   logic              moving_ff, moving_in;

   logic              rsp_valid_ff, rsp_valid_in;
   ssl_pkg::deg_type  rsp_pos_ff [ssl_pkg::AXES];
   logic [5:0]        rsp_mask_ff, rsp_mask_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              req_fire;
   logic              is_move;
   logic              step_fire;
   logic              all_done;

   // Accept whenever the output register is free or draining this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_move   = (req_cmd == ssl_pkg::CMD_MOVE);
   assign step_fire = req_fire && !is_move && moving_ff && (countdown_ff == 5'd0);

   assign req_tgt[0] = req_target_base;
   assign req_tgt[1] = req_target_shoulder;
   assign req_tgt[2] = req_target_elbow;
   assign req_tgt[3] = req_target_wrist_rotation;
   assign req_tgt[4] = req_target_wrist_vertical;
   assign req_tgt[5] = req_target_gripper;

   assign ival_req = ssl_pkg::clamp_ival(req_step_interval);

   // Per-axis clamp and stepper
   for (genvar i = 0; i < ssl_pkg::AXES; i++) begin : g_axis
      assign tgt_req[i] = ssl_pkg::clamp_deg(req_tgt[i], ssl_pkg::LO_LIM[i],
                                             ssl_pkg::HI_LIM[i]);
      ssl_axis u_axis (
         .pos      (pos_ff[i]),
         .tgt      (tgt_ff[i]),
         .pos_next (pos_step[i]),
         .stat     (stat[i])
      );
      assign rsp_mask_in[i] = stat[i].moved;
   end

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < ssl_pkg::AXES; i++) begin
         all_done = all_done && stat[i].arrived;
      end
   end

   assign rsp_done_in = all_done;

   // Next-state logic for the move state
   always_comb begin
      interval_in  = interval_ff;
      countdown_in = countdown_ff;
      moving_in    = moving_ff;
      for (int i = 0; i < ssl_pkg::AXES; i++) begin
         pos_in[i] = pos_ff[i];
         tgt_in[i] = tgt_ff[i];
      end
      if (req_fire && is_move) begin
         interval_in  = ival_req;
         countdown_in = ival_req - 5'd1;
         moving_in    = 1'b1;
         for (int i = 0; i < ssl_pkg::AXES; i++) begin
            tgt_in[i] = tgt_req[i];
         end
      end else if (step_fire) begin
         countdown_in = interval_ff - 5'd1;
         moving_in    = !all_done;
         for (int i = 0; i < ssl_pkg::AXES; i++) begin
            pos_in[i] = pos_step[i];
         end
      end else if (req_fire && moving_ff) begin
         countdown_in = countdown_ff - 5'd1;
      end
   end

   // Output register valid
   always_comb begin
      if (step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= ssl_pkg::IVAL_MIN[4:0];
         countdown_ff <= 5'd0;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ssl_pkg::AXES; i++) begin
            pos_ff[i] <= ssl_pkg::HOME_POS[i];
            tgt_ff[i] <= ssl_pkg::HOME_POS[i];
         end
      end else begin
         interval_ff  <= interval_in;
         countdown_ff <= countdown_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ssl_pkg::AXES; i++) begin
            pos_ff[i] <= pos_in[i];
            tgt_ff[i] <= tgt_in[i];
         end
      end
   end

   // Response payload, loaded on a stepping tick
   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_mask_ff <= rsp_mask_in;
         rsp_done_ff <= rsp_done_in;
         for (int i = 0; i < ssl_pkg::AXES; i++) begin
            rsp_pos_ff[i] <= pos_step[i];
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_pos_base           = rsp_pos_ff[0];
   assign rsp_pos_shoulder       = rsp_pos_ff[1];
   assign rsp_pos_elbow          = rsp_pos_ff[2];
   assign rsp_pos_wrist_rotation = rsp_pos_ff[3];
   assign rsp_pos_wrist_vertical = rsp_pos_ff[4];
   assign rsp_pos_gripper        = rsp_pos_ff[5];
   assign rsp_moved_mask         = rsp_mask_ff;
   assign rsp_done_res           = rsp_done_ff;

`ifndef SYNTHESIS
   // Positions never leave the axis limits
   for (genvar i = 0; i < ssl_pkg::AXES; i++) begin : g_chk
      a_pos_range: assert property (@(posedge clock) disable iff (reset)
         (pos_ff[i] >= ssl_pkg::LO_LIM[i]) && (pos_ff[i] <= ssl_pkg::HI_LIM[i]))
         else $error("axis position outside its limits");
   end

   // Interval stays in the legal range
   a_ival_range: assert property (@(posedge clock) disable iff (reset)
      (interval_ff >= ssl_pkg::IVAL_MIN[4:0]) && (interval_ff <= ssl_pkg::IVAL_MAX[4:0]))
      else $error("step interval out of range");

   // Countdown is always below the interval during a move
   a_countdown: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (countdown_ff < interval_ff))
      else $error("countdown not below interval");

   // A new response only comes from a tick during an active move
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(moving_ff))
      else $error("response produced while idle");
`endif

endmodule

[verif/six_axis_servo_slew_limiter_tb.sv]
// Self-checking testbench for the six-axis servo slew limiter.
`timescale 1ns / 1ps

module six_axis_servo_slew_limiter_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS = 1350;
   localparam int BURST_ITEMS = 300;

   typedef logic [5:0][9:0] target_set_type;

   // One expected response: post-step positions, moved axes, done flag
   typedef struct packed {
      logic [5:0][7:0] pos;
      logic [5:0] mask;
      logic done;
   } servo_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = ssl_pkg::CMD_TICK;
   logic [7:0] req_step_interval = 8'd0;
   logic signed [9:0] req_target_base = 10'sd0;
   logic signed [9:0] req_target_shoulder = 10'sd0;
   logic signed [9:0] req_target_elbow = 10'sd0;
   logic signed [9:0] req_target_wrist_rotation = 10'sd0;
   logic signed [9:0] req_target_wrist_vertical = 10'sd0;
   logic signed [9:0] req_target_gripper = 10'sd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_pos_base;
   logic [7:0] rsp_pos_shoulder;
   logic [7:0] rsp_pos_elbow;
   logic [7:0] rsp_pos_wrist_rotation;
   logic [7:0] rsp_pos_wrist_vertical;
   logic [7:0] rsp_pos_gripper;
   logic [5:0] rsp_moved_mask;
   logic rsp_done_res;

   six_axis_servo_slew_limiter i_dut (.*);

   // Predicted servo state
   logic [7:0] servo_pos [6];
   logic [7:0] servo_goal [6];
   logic [4:0] step_ticks;
   logic [4:0] tick_count;
   logic in_motion;
   servo_report_type pending_reports [$];
   servo_report_type seen_report;

   int error_count = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   bit burst_mode = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Axis order: base, shoulder, elbow, wrist rotation, wrist vertical, gripper
   function automatic int axis_lo(input int i);
      case (i)
         1: return 15;
         5: return 10;
         default: return 0;
      endcase
   endfunction

   function automatic int axis_hi(input int i);
      case (i)
         1: return 165;
         5: return 73;
         default: return 180;
      endcase
   endfunction

   function automatic int home_deg(input int i);
      case (i)
         0: return 90;
         1: return 45;
         2: return 180;
         3: return 90;
         4: return 180;
         default: return 10;
      endcase
   endfunction

   function automatic logic [7:0] limit_target(input logic signed [9:0] v,
                                               input int lo, input int hi);
      int s;
      s = int'(v);
      if (s < lo) s = lo;
      if (s > hi) s = hi;
      return s[7:0];
   endfunction

   function automatic int draw_gap();
      if (burst_mode) return 0;
      return $urandom_range(0, 19);
   endfunction

   task automatic reset_prediction();
      for (int i = 0; i < 6; i++) begin
         servo_pos[i] = 8'(home_deg(i));
         servo_goal[i] = 8'(home_deg(i));
      end
      step_ticks = 5'd10;
      tick_count = 5'd0;
      in_motion = 1'b0;
   endtask

   // Advance the predicted state by one accepted request
   task automatic predict_request(input logic cmd, input logic [7:0] ival,
                                  input target_set_type tgt);
      int iv;
      logic all_there;
      servo_report_type rpt;
      if (cmd == ssl_pkg::CMD_MOVE) begin
         iv = int'(ival);
         if (iv > int'(ssl_pkg::IVAL_MAX)) iv = int'(ssl_pkg::IVAL_MAX);
         if (iv < int'(ssl_pkg::IVAL_MIN)) iv = int'(ssl_pkg::IVAL_MIN);
         step_ticks = iv[4:0];
         for (int i = 0; i < 6; i++)
            servo_goal[i] = limit_target($signed(tgt[i]), axis_lo(i), axis_hi(i));
         tick_count = step_ticks - 5'd1;
         in_motion = 1'b1;
      end else if (in_motion) begin
         if (tick_count != 5'd0) begin
            tick_count = tick_count - 5'd1;
         end else begin
            // Stepping tick: every axis off target moves one degree
            rpt.mask = 6'd0;
            all_there = 1'b1;
            for (int i = 0; i < 6; i++) begin
               if (servo_pos[i] < servo_goal[i]) begin
                  servo_pos[i] = servo_pos[i] + 8'd1;
                  rpt.mask[i] = 1'b1;
               end else if (servo_pos[i] > servo_goal[i]) begin
                  servo_pos[i] = servo_pos[i] - 8'd1;
                  rpt.mask[i] = 1'b1;
               end
               if (servo_pos[i] != servo_goal[i]) all_there = 1'b0;
               rpt.pos[i] = servo_pos[i];
            end
            rpt.done = all_there;
            tick_count = step_ticks - 5'd1;
            if (all_there) in_motion = 1'b0;
            pending_reports.push_back(rpt);
         end
      end
   endtask

   // Present one request after a random gap and hold it until accepted
   task automatic send_request(input logic cmd, input logic [7:0] ival,
                               input target_set_type tgt);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_step_interval <= ival;
      req_target_base <= tgt[0];
      req_target_shoulder <= tgt[1];
      req_target_elbow <= tgt[2];
      req_target_wrist_rotation <= tgt[3];
      req_target_wrist_vertical <= tgt[4];
      req_target_gripper <= tgt[5];
      do @(posedge clock); while (!req_ready);
      predict_request(cmd, ival, tgt);
      items_sent++;
   endtask

   function automatic target_set_type junk_targets();
      target_set_type tgt;
      for (int i = 0; i < 6; i++) tgt[i] = 10'($urandom);
      return tgt;
   endfunction

   // Tick with random don't-care fields
   task automatic send_tick();
      send_request(ssl_pkg::CMD_TICK, 8'($urandom), junk_targets());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic test_idle_tick();
      send_tick();
      send_tick();
      wait_drained();
   endtask

   // Move to where the servos already are; interval below range clamps up
   task automatic test_move_in_place();
      target_set_type tgt;
      for (int i = 0; i < 6; i++) tgt[i] = 10'(home_deg(i));
      send_request(ssl_pkg::CMD_MOVE, 8'd0, tgt);
      repeat (10) send_tick();
      wait_drained();
   endtask

   // Extreme targets, then a retarget mid-move that restarts the countdown
   task automatic test_retarget_during_move();
      target_set_type tgt;
      for (int i = 0; i < 6; i++) tgt[i] = 10'h200;
      send_request(ssl_pkg::CMD_MOVE, 8'd255, tgt);
      for (int i = 0; i < 6; i++) tgt[i] = 10'h1FF;
      send_request(ssl_pkg::CMD_MOVE, 8'd9, tgt);
      repeat (10) send_tick();
      wait_drained();
   endtask

   // One move request followed by a run of ticks
   task automatic run_move_sequence();
      target_set_type tgt;
      int kind;
      int t;
      int ticks;
      logic [7:0] ival;
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) ival = 8'($urandom);
      else ival = 8'($urandom_range(0, 33));
      for (int i = 0; i < 6; i++) begin
         if (kind < 7) begin
            // near the present position, may fall past a limit
            t = int'(servo_pos[i]);
            t = t + $urandom_range(0, 8);
            t = t - 4;
         end else if (kind == 7) begin
            case ($urandom_range(0, 3))
               0: t = axis_lo(i) - 1;
               1: t = axis_lo(i);
               2: t = axis_hi(i);
               default: t = axis_hi(i) + 1;
            endcase
         end else begin
            t = $urandom_range(0, 1023);
         end
         tgt[i] = t[9:0];
      end
      send_request(ssl_pkg::CMD_MOVE, ival, tgt);
      if (kind < 7 && $urandom_range(0, 4) != 0) begin
         // well-formed: run to completion, then a few idle ticks
         while (in_motion) send_tick();
         ticks = $urandom_range(0, 3);
      end else begin
         // broken off by the next move request
         ticks = $urandom_range(0, 60);
      end
      repeat (ticks) send_tick();
   endtask

   task automatic test_random_moves();
      int stop_at;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         run_move_sequence();
      end
      burst_mode = 1'b0;
      wait_drained();
   endtask

   task automatic test_back_to_back();
      int stop_at;
      stop_at = items_sent + BURST_ITEMS;
      burst_mode = 1'b1;
      while (items_sent < stop_at) run_move_sequence();
      wait_drained();
      burst_mode = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Response sink with a random stall before each response
   initial begin : rsp_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("response with no prediction pending");
            error_count++;
         end else begin
            seen_report = pending_reports.pop_front();
            check_field("pos_base", seen_report.pos[0], rsp_pos_base);
            check_field("pos_shoulder", seen_report.pos[1], rsp_pos_shoulder);
            check_field("pos_elbow", seen_report.pos[2], rsp_pos_elbow);
            check_field("pos_wrist_rotation", seen_report.pos[3], rsp_pos_wrist_rotation);
            check_field("pos_wrist_vertical", seen_report.pos[4], rsp_pos_wrist_vertical);
            check_field("pos_gripper", seen_report.pos[5], rsp_pos_gripper);
            check_field("moved_mask", {2'b00, seen_report.mask}, {2'b00, rsp_moved_mask});
            check_field("done_res", {7'd0, seen_report.done}, {7'd0, rsp_done_res});
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("six_axis_servo_slew_limiter_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      reset_prediction();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_idle_tick();
      test_move_in_place();
      test_retarget_during_move();
      test_random_moves();
      test_back_to_back();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("six_axis_servo_slew_limiter_tb: done, clean");
      end else begin
         $display("six_axis_servo_slew_limiter_tb: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
sv/ssl_pkg.sv
sv/ssl_axis.sv
sv/six_axis_servo_slew_limiter.sv
verif/six_axis_servo_slew_limiter_tb.sv
